// ----- sv/isc_pkg.sv -----
package isc_pkg;

  localparam int DEPTH    = 16;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CAP_W    = 5;
  localparam int CMD_W    = 3;
  localparam int ST_W     = 2;
  localparam int OUTCNT_W = 5;
  localparam int PC_W     = 6;
  localparam int IN_W     = ((CMD_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_W    = ((DATA_W + ST_W + OUTCNT_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_ADD    = 3'd2,
    CMD_SUB    = 3'd3,
    CMD_MUL    = 3'd4,
    CMD_DIV    = 3'd5,
    CMD_SUMALL = 3'd6,
    CMD_PRODALL = 3'd7
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_FEW  = 2'd2,
    ST_DIVZ = 2'd3
  } st_t;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_TOP  = 2'd1,
    RD_SEC  = 2'd2,
    RD_IDX  = 2'd3
  } rd_t;

  typedef enum logic [3:0] {
    ALU_NONE   = 4'd0,
    ALU_ZERO   = 4'd1,
    ALU_ONE    = 4'd2,
    ALU_VAL    = 4'd3,
    ALU_RD     = 4'd4,
    ALU_ADD    = 4'd5,
    ALU_SUB    = 4'd6,
    ALU_MUL    = 4'd7,
    ALU_DIVGO  = 4'd8,
    ALU_QUO    = 4'd9,
    ALU_ACCADD = 4'd10,
    ALU_ACCMUL = 4'd11
  } alu_t;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_PUSH = 2'd1,
    WR_SEC  = 2'd2,
    WR_BASE = 2'd3
  } wr_t;

  typedef enum logic [1:0] {
    CNT_KEEP = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_ONE  = 2'd3
  } cnt_op_t;

  typedef enum logic [1:0] {
    IDX_KEEP = 2'd0,
    IDX_CLR  = 2'd1,
    IDX_INC  = 2'd2
  } idx_op_t;

  typedef enum logic [2:0] {
    JC_NEXT    = 3'd0,
    JC_ALWAYS  = 3'd1,
    JC_FULL    = 3'd2,
    JC_EMPTY   = 3'd3,
    JC_FEW     = 3'd4,
    JC_AZERO   = 3'd5,
    JC_IDXEND  = 3'd6,
    JC_DIVBUSY = 3'd7
  } jc_t;

  typedef struct packed {
    rd_t             rd;
    logic            ld_a;
    logic            ld_b;
    alu_t            alu;
    wr_t             wr;
    cnt_op_t         cnt;
    idx_op_t         idx;
    jc_t             jc;
    logic [PC_W-1:0] tgt;
    logic            fin;
    st_t             st;
  } ucw_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic few;
    logic a_zero;
    logic idx_end;
    logic div_busy;
  } flags_t;

  localparam logic [PC_W-1:0] UA_PUSH0   = PC_W'(0);
  localparam logic [PC_W-1:0] UA_PUSH1   = PC_W'(1);
  localparam logic [PC_W-1:0] UA_POP0    = PC_W'(2);
  localparam logic [PC_W-1:0] UA_POP1    = PC_W'(3);
  localparam logic [PC_W-1:0] UA_ADD0    = PC_W'(4);
  localparam logic [PC_W-1:0] UA_ADD1    = PC_W'(5);
  localparam logic [PC_W-1:0] UA_ADD2    = PC_W'(6);
  localparam logic [PC_W-1:0] UA_ADD3    = PC_W'(7);
  localparam logic [PC_W-1:0] UA_SUB0    = PC_W'(8);
  localparam logic [PC_W-1:0] UA_SUB1    = PC_W'(9);
  localparam logic [PC_W-1:0] UA_SUB2    = PC_W'(10);
  localparam logic [PC_W-1:0] UA_SUB3    = PC_W'(11);
  localparam logic [PC_W-1:0] UA_MUL0    = PC_W'(12);
  localparam logic [PC_W-1:0] UA_MUL1    = PC_W'(13);
  localparam logic [PC_W-1:0] UA_MUL2    = PC_W'(14);
  localparam logic [PC_W-1:0] UA_MUL3    = PC_W'(15);
  localparam logic [PC_W-1:0] UA_DIV0    = PC_W'(16);
  localparam logic [PC_W-1:0] UA_DIV1    = PC_W'(17);
  localparam logic [PC_W-1:0] UA_DIV2    = PC_W'(18);
  localparam logic [PC_W-1:0] UA_DIV3    = PC_W'(19);
  localparam logic [PC_W-1:0] UA_DIV4    = PC_W'(20);
  localparam logic [PC_W-1:0] UA_DIV5    = PC_W'(21);
  localparam logic [PC_W-1:0] UA_TAIL    = PC_W'(22);
  localparam logic [PC_W-1:0] UA_SUMA0   = PC_W'(23);
  localparam logic [PC_W-1:0] UA_SUMA1   = PC_W'(24);
  localparam logic [PC_W-1:0] UA_SUMA2   = PC_W'(25);
  localparam logic [PC_W-1:0] UA_PRODA0  = PC_W'(26);
  localparam logic [PC_W-1:0] UA_PRODA1  = PC_W'(27);
  localparam logic [PC_W-1:0] UA_PRODA2  = PC_W'(28);
  localparam logic [PC_W-1:0] UA_FOLDEND = PC_W'(29);
  localparam logic [PC_W-1:0] UA_EFULL   = PC_W'(30);
  localparam logic [PC_W-1:0] UA_EFEW    = PC_W'(31);
  localparam logic [PC_W-1:0] UA_EDIVZ   = PC_W'(32);

  localparam ucw_t UCW_NOP = '{
    rd: RD_NONE, ld_a: 1'b0, ld_b: 1'b0, alu: ALU_NONE, wr: WR_NONE,
    cnt: CNT_KEEP, idx: IDX_KEEP, jc: JC_NEXT, tgt: '0, fin: 1'b0, st: ST_OK
  };

  function automatic logic [PC_W-1:0] dispatch(input cmd_t cmd);
    logic [PC_W-1:0] a;
    case (cmd)
      CMD_PUSH:    a = UA_PUSH0;
      CMD_POP:     a = UA_POP0;
      CMD_ADD:     a = UA_ADD0;
      CMD_SUB:     a = UA_SUB0;
      CMD_MUL:     a = UA_MUL0;
      CMD_DIV:     a = UA_DIV0;
      CMD_SUMALL:  a = UA_SUMA0;
      default:     a = UA_PRODA0;
    endcase
    return a;
  endfunction

  // microprogram: one control word per step
  function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = UCW_NOP;
    case (pc)
      UA_PUSH0: begin
        w.jc = JC_FULL; w.tgt = UA_EFULL;
      end
      UA_PUSH1: begin
        w.wr = WR_PUSH; w.cnt = CNT_INC; w.alu = ALU_VAL; w.fin = 1'b1;
      end
      UA_POP0: begin
        w.rd = RD_TOP; w.jc = JC_EMPTY; w.tgt = UA_EFEW;
      end
      UA_POP1: begin
        w.alu = ALU_RD; w.cnt = CNT_DEC; w.fin = 1'b1;
      end
      UA_ADD0, UA_SUB0, UA_MUL0, UA_DIV0: begin
        w.rd = RD_TOP; w.jc = JC_FEW; w.tgt = UA_EFEW;
      end
      UA_ADD1, UA_SUB1, UA_MUL1, UA_DIV1: begin
        w.rd = RD_SEC; w.ld_a = 1'b1;
      end
      UA_ADD2, UA_SUB2, UA_MUL2: begin
        w.ld_b = 1'b1;
      end
      UA_ADD3: begin
        w.alu = ALU_ADD; w.jc = JC_ALWAYS; w.tgt = UA_TAIL;
      end
      UA_SUB3: begin
        w.alu = ALU_SUB; w.jc = JC_ALWAYS; w.tgt = UA_TAIL;
      end
      UA_MUL3: begin
        w.alu = ALU_MUL; w.jc = JC_ALWAYS; w.tgt = UA_TAIL;
      end
      UA_DIV2: begin
        w.ld_b = 1'b1; w.jc = JC_AZERO; w.tgt = UA_EDIVZ;
      end
      UA_DIV3: begin
        w.alu = ALU_DIVGO;
      end
      UA_DIV4: begin
        w.jc = JC_DIVBUSY; w.tgt = UA_DIV4;
      end
      UA_DIV5: begin
        w.alu = ALU_QUO; w.jc = JC_ALWAYS; w.tgt = UA_TAIL;
      end
      UA_TAIL: begin
        w.wr = WR_SEC; w.cnt = CNT_DEC; w.fin = 1'b1;
      end
      UA_SUMA0: begin
        w.alu = ALU_ZERO; w.idx = IDX_CLR;
      end
      UA_SUMA1, UA_PRODA1: begin
        w.rd = RD_IDX; w.idx = IDX_INC; w.jc = JC_IDXEND; w.tgt = UA_FOLDEND;
      end
      UA_SUMA2: begin
        w.alu = ALU_ACCADD; w.jc = JC_ALWAYS; w.tgt = UA_SUMA1;
      end
      UA_PRODA0: begin
        w.alu = ALU_ONE; w.idx = IDX_CLR;
      end
      UA_PRODA2: begin
        w.alu = ALU_ACCMUL; w.jc = JC_ALWAYS; w.tgt = UA_PRODA1;
      end
      UA_FOLDEND: begin
        w.wr = WR_BASE; w.cnt = CNT_ONE; w.fin = 1'b1;
      end
      UA_EFULL: begin
        w.alu = ALU_ZERO; w.fin = 1'b1; w.st = ST_FULL;
      end
      UA_EFEW: begin
        w.alu = ALU_ZERO; w.fin = 1'b1; w.st = ST_FEW;
      end
      UA_EDIVZ: begin
        w.alu = ALU_ZERO; w.fin = 1'b1; w.st = ST_DIVZ;
      end
      default: begin
        w = UCW_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- sv/integer_stack_calculator.sv -----
// from accepted word to result register the sequencer steps through a microprogram for
// push, pop, add, subtract, multiply, divide (iterative divider), add-all and multiply-all
// (one stack ram read per entry and a final one, one read port)
// throughput: one word at a time, the next is taken the cycle after the result is registered
// reset (rst_n low, synchronous): stack empty, capacity 16, sequencer idle; stack ram
// contents are not cleared
module integer_stack_calculator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // command [2:0], value [34:3], zero pad
  input  logic [isc_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // result_value [31:0], status [33:32], entry_count [38:34], zero pad
  output logic [isc_pkg::OUT_W-1:0]   out_tdata,
  input  logic                        cfg_we,
  input  logic [isc_pkg::CAP_W-1:0]   cfg_wdata
);

  localparam int W   = isc_pkg::DATA_W;
  localparam int CW  = isc_pkg::CNT_W;
  localparam int AW  = isc_pkg::ADDR_W;

  logic [isc_pkg::CAP_W-1:0] cap_r;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic [W-1:0]              a_r, b_r, val_r;
  logic [W-1:0]              res_r, res_nxt;
  logic                      out_valid_r;
  logic [isc_pkg::OUT_W-1:0] out_data_r;

  logic                      accept;
  logic                      seq_busy, run, hold;
  isc_pkg::ucw_t             cw;
  isc_pkg::flags_t           flags;
  logic [CW-1:0]             eff_cap;
  logic [CW-1:0]             cnt_m1, cnt_m2;

  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [W-1:0]              ram_wdata, ram_rdata;

  logic [W-1:0]              mul_x, mul_y;
  logic [2*W-1:0]            prod;
  logic                      div_busy;
  logic [W-1:0]              div_quo;

  assign in_tready = !seq_busy;
  assign accept    = in_tvalid && in_tready;
  assign hold      = cw.fin && out_valid_r && !out_tready;

  isc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .cmd   (isc_pkg::cmd_t'(in_tdata[isc_pkg::CMD_W-1:0])),
    .flags (flags),
    .hold  (hold),
    .cw    (cw),
    .busy  (seq_busy),
    .run   (run)
  );

  // capacity clamped to 1..DEPTH
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CW'(1);
    end else if (int'(cap_r) > isc_pkg::DEPTH) begin
      eff_cap = CW'(isc_pkg::DEPTH);
    end else begin
      eff_cap = CW'(cap_r);
    end
  end

  assign cnt_m1 = cnt_r - CW'(1);
  assign cnt_m2 = cnt_r - CW'(2);

  assign flags.full     = (cnt_r >= eff_cap);
  assign flags.empty    = (cnt_r == '0);
  assign flags.few      = (cnt_r < CW'(2));
  assign flags.a_zero   = (a_r == '0);
  assign flags.idx_end  = (idx_r == cnt_r);
  assign flags.div_busy = div_busy;

  assign ram_re = run && (cw.rd != isc_pkg::RD_NONE);
  assign ram_we = run && (cw.wr != isc_pkg::WR_NONE);

  always_comb begin
    case (cw.rd)
      isc_pkg::RD_TOP: ram_raddr = cnt_m1[AW-1:0];
      isc_pkg::RD_SEC: ram_raddr = cnt_m2[AW-1:0];
      isc_pkg::RD_IDX: ram_raddr = idx_r[AW-1:0];
      default:         ram_raddr = '0;
    endcase
  end

  always_comb begin
    case (cw.wr)
      isc_pkg::WR_PUSH: begin
        ram_waddr = cnt_r[AW-1:0];
        ram_wdata = val_r;
      end
      isc_pkg::WR_SEC: begin
        ram_waddr = cnt_m2[AW-1:0];
        ram_wdata = res_r;
      end
      default: begin
        ram_waddr = '0;
        ram_wdata = res_r;
      end
    endcase
  end

  isc_ram #(
    .DEPTH (isc_pkg::DEPTH),
    .WIDTH (W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // quotient is second divided by top
  isc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (run && (cw.alu == isc_pkg::ALU_DIVGO)),
    .dividend (b_r),
    .divisor  (a_r),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // one shared multiplier, low half of the product kept
  assign mul_x = (cw.alu == isc_pkg::ALU_ACCMUL) ? res_r : a_r;
  assign mul_y = (cw.alu == isc_pkg::ALU_ACCMUL) ? ram_rdata : b_r;
  assign prod  = mul_x * mul_y;

  always_comb begin
    res_nxt = res_r;
    if (run) begin
      case (cw.alu)
        isc_pkg::ALU_ZERO:   res_nxt = '0;
        isc_pkg::ALU_ONE:    res_nxt = W'(1);
        isc_pkg::ALU_VAL:    res_nxt = val_r;
        isc_pkg::ALU_RD:     res_nxt = ram_rdata;
        isc_pkg::ALU_ADD:    res_nxt = a_r + b_r;
        isc_pkg::ALU_SUB:    res_nxt = a_r - b_r;
        isc_pkg::ALU_MUL:    res_nxt = prod[W-1:0];
        isc_pkg::ALU_QUO:    res_nxt = div_quo;
        isc_pkg::ALU_ACCADD: res_nxt = res_r + ram_rdata;
        isc_pkg::ALU_ACCMUL: res_nxt = prod[W-1:0];
        default:             res_nxt = res_r;
      endcase
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (run) begin
      case (cw.cnt)
        isc_pkg::CNT_INC: cnt_nxt = cnt_r + CW'(1);
        isc_pkg::CNT_DEC: cnt_nxt = cnt_m1;
        isc_pkg::CNT_ONE: cnt_nxt = CW'(1);
        default:          cnt_nxt = cnt_r;
      endcase
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (run) begin
      case (cw.idx)
        isc_pkg::IDX_CLR: idx_nxt = '0;
        isc_pkg::IDX_INC: idx_nxt = idx_r + CW'(1);
        default:          idx_nxt = idx_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= isc_pkg::CAP_W'(16);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      cnt_r <= cnt_nxt;
      if (run && cw.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    if (accept) begin
      val_r <= in_tdata[isc_pkg::CMD_W +: W];
    end
    if (run && cw.ld_a) begin
      a_r <= ram_rdata;
    end
    if (run && cw.ld_b) begin
      b_r <= ram_rdata;
    end
    if (run && cw.fin) begin
      out_data_r <= isc_pkg::OUT_W'({isc_pkg::OUTCNT_W'(cnt_nxt), cw.st, res_nxt});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> seq_busy)
    else $error("accepted word did not start the sequencer");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= isc_pkg::DEPTH)
    else $error("entry count beyond stack depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (run && (cw.wr == isc_pkg::WR_PUSH)) |-> !flags.full)
    else $error("push written into a full stack");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (run && (cw.alu == isc_pkg::ALU_DIVGO)) |-> (a_r != '0))
    else $error("divider started with a zero divisor");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (run && cw.fin && out_valid_r) |-> out_tready)
    else $error("result register overwritten before it was taken");

endmodule

// ----- sv/isc_ram.sv -----
module isc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/isc_div.sv -----
module isc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [isc_pkg::DATA_W-1:0] dividend,
  input  logic [isc_pkg::DATA_W-1:0] divisor,
  output logic                      busy,
  output logic [isc_pkg::DATA_W-1:0] quotient
);

  localparam int W  = isc_pkg::DATA_W;
  localparam int SW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic          neg_r, neg_nxt;
  logic [W:0]    rem_sh;

  // restoring divide on magnitudes, one quotient bit a cycle
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    rem_sh   = {rem_r[W-1:0], quo_r[W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend[W-1] ? (~dividend + W'(1)) : dividend;
      dsr_nxt  = divisor[W-1] ? (~divisor + W'(1)) : divisor;
      neg_nxt  = dividend[W-1] ^ divisor[W-1];
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = rem_sh - {1'b0, dsr_r};
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      step_nxt = step_r + SW'(1);
      if (step_r == SW'(W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? (~quo_r + W'(1)) : quo_r;

endmodule

// ----- sv/isc_seq.sv -----
module isc_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  isc_pkg::cmd_t     cmd,
  input  isc_pkg::flags_t   flags,
  input  logic              hold,
  output isc_pkg::ucw_t     cw,
  output logic              busy,
  output logic              run
);

  typedef enum logic [1:0] {
    SQ_IDLE = 2'b01,
    SQ_RUN  = 2'b10
  } sq_state_t;

  sq_state_t                   state_r, state_nxt;
  logic [isc_pkg::PC_W-1:0]    pc_r, pc_nxt;
  logic                        take;

  assign cw   = isc_pkg::ucode_rom(pc_r);
  assign busy = (state_r == SQ_RUN);
  assign run  = busy && !hold;

  always_comb begin
    case (cw.jc)
      isc_pkg::JC_NEXT:    take = 1'b0;
      isc_pkg::JC_ALWAYS:  take = 1'b1;
      isc_pkg::JC_FULL:    take = flags.full;
      isc_pkg::JC_EMPTY:   take = flags.empty;
      isc_pkg::JC_FEW:     take = flags.few;
      isc_pkg::JC_AZERO:   take = flags.a_zero;
      isc_pkg::JC_IDXEND:  take = flags.idx_end;
      isc_pkg::JC_DIVBUSY: take = flags.div_busy;
      default:             take = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    case (state_r)
      SQ_IDLE: begin
        if (start) begin
          state_nxt = SQ_RUN;
          pc_nxt    = isc_pkg::dispatch(cmd);
        end
      end
      SQ_RUN: begin
        if (run) begin
          if (cw.fin) begin
            state_nxt = SQ_IDLE;
          end else if (take) begin
            pc_nxt = cw.tgt;
          end else begin
            pc_nxt = pc_r + isc_pkg::PC_W'(1);
          end
        end
      end
      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

// ----- tb/stack_checker.sv -----
module stack_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  // command [2:0], value [34:3], zero pad
  input  logic [isc_pkg::IN_W-1:0]   in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  // result_value [31:0], status [33:32], entry_count [38:34], zero pad
  input  logic [isc_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_we,
  input  logic [isc_pkg::CAP_W-1:0]  cfg_wdata,
  output int                         fails,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import isc_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0]   value;
    st_t                 status;
    logic [OUTCNT_W-1:0] count;
  } calc_result_t;

  logic [DATA_W-1:0] stack_mem [DEPTH];
  int unsigned       depth_used;
  logic [CAP_W-1:0]  capacity;
  calc_result_t      expected_results [$];

  function automatic int unsigned usable_depth();
    if (capacity == '0) return 1;
    if (capacity > DEPTH) return DEPTH;
    return 32'(capacity);
  endfunction

  // truncating signed divide on magnitudes, min / -1 wraps back to min
  function automatic logic [DATA_W-1:0] div_trunc(input logic [DATA_W-1:0] num,
                                                  input logic [DATA_W-1:0] den);
    logic [DATA_W-1:0] mag_n, mag_d, quo;
    mag_n = num[DATA_W-1] ? '0 - num : num;
    mag_d = den[DATA_W-1] ? '0 - den : den;
    quo = mag_n / mag_d;
    return (num[DATA_W-1] ^ den[DATA_W-1]) ? '0 - quo : quo;
  endfunction

  function automatic calc_result_t apply_command(input cmd_t cmd,
                                                 input logic [DATA_W-1:0] val);
    calc_result_t      r;
    logic [DATA_W-1:0] top_w, sec_w, acc;
    int unsigned       i;
    r.value = '0;
    r.status = ST_OK;
    acc = '0;
    case (cmd)
      CMD_PUSH: begin
        if (depth_used >= usable_depth()) begin
          r.status = ST_FULL;
        end else begin
          stack_mem[depth_used] = val;
          depth_used++;
          r.value = val;
        end
      end
      CMD_POP: begin
        if (depth_used == 0) begin
          r.status = ST_FEW;
        end else begin
          depth_used--;
          r.value = stack_mem[depth_used];
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (depth_used < 2) begin
          r.status = ST_FEW;
        end else begin
          top_w = stack_mem[depth_used-1];
          sec_w = stack_mem[depth_used-2];
          case (cmd)
            CMD_ADD: acc = top_w + sec_w;
            CMD_SUB: acc = top_w - sec_w;
            CMD_MUL: acc = top_w * sec_w;
            default: begin
              if (top_w == '0) r.status = ST_DIVZ;
              else acc = div_trunc(sec_w, top_w);
            end
          endcase
          if (r.status == ST_OK) begin
            depth_used--;
            stack_mem[depth_used-1] = acc;
            r.value = acc;
          end
        end
      end
      CMD_SUMALL: begin
        acc = '0;
        for (i = 0; i < depth_used; i++) acc = acc + stack_mem[i];
        stack_mem[0] = acc;
        depth_used = 1;
        r.value = acc;
      end
      default: begin
        acc = DATA_W'(1);
        for (i = 0; i < depth_used; i++) acc = acc * stack_mem[i];
        stack_mem[0] = acc;
        depth_used = 1;
        r.value = acc;
      end
    endcase
    r.count = OUTCNT_W'(depth_used);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    calc_result_t want, got;
    if (!rst_n) begin
      depth_used = 0;
      capacity = CAP_W'(16);
      fails = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[31:0];
        got.status = st_t'(out_tdata[33:32]);
        got.count = out_tdata[38:34];
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word %h, expected none", $time, out_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: expected %h st %0d cnt %0d, actual %h st %0d cnt %0d",
                     $time, want.value, want.status, want.count,
                     got.value, got.status, got.count);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_command(cmd_t'(in_tdata[2:0]), in_tdata[34:3]));
    end
    pending = expected_results.size();
  end

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import isc_pkg::*;

  localparam int STALL_LIMIT     = 3000;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int SETTLE_CYCLES   = 45;
  localparam int HOLD_CYCLES     = 400;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_we;
  logic [CAP_W-1:0]  cfg_wdata;

  int                fails;
  int                pending;
  int                stall_cycles;
  bit                steady;
  bit                hold_req;
  bit                hold_done;
  logic [CAP_W-1:0]  phase_caps [NUM_PHASES];

  integer_stack_calculator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  stack_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fails      (fails),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random back-pressure, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= steady || ($urandom_range(0, 99) >= 24);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic cmd_t pick_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return CMD_PUSH;
    if (r < 60) return CMD_POP;
    if (r < 68) return CMD_ADD;
    if (r < 76) return CMD_SUB;
    if (r < 84) return CMD_MUL;
    if (r < 93) return CMD_DIV;
    if (r < 96) return CMD_SUMALL;
    return CMD_PRODALL;
  endfunction

  // small values often, so divide by zero and short products show up
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      4, 5: return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input cmd_t cmd, input logic [DATA_W-1:0] val);
    while (!steady && $urandom_range(0, 99) < 24) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_W - CMD_W - DATA_W){1'b0}}, val, cmd};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    steady = 1'b0;
    hold_req = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty stack corner cases, then wrap and divide corners
    send_word(CMD_POP, $urandom);
    send_word(CMD_ADD, $urandom);
    send_word(CMD_SUMALL, $urandom);
    send_word(CMD_POP, $urandom);
    send_word(CMD_PRODALL, $urandom);
    send_word(CMD_SUB, $urandom);
    send_word(CMD_POP, $urandom);
    send_word(CMD_PUSH, 32'h7fff_ffff);
    send_word(CMD_PUSH, 32'h8000_0000);
    send_word(CMD_ADD, $urandom);
    send_word(CMD_PUSH, 32'h0000_0000);
    send_word(CMD_DIV, $urandom);
    send_word(CMD_POP, $urandom);
    send_word(CMD_POP, $urandom);
    send_word(CMD_PUSH, 32'h8000_0000);
    send_word(CMD_PUSH, 32'hffff_ffff);
    send_word(CMD_DIV, $urandom);
    send_word(CMD_PUSH, 32'd7);
    send_word(CMD_SUB, $urandom);
    send_word(CMD_PUSH, 32'd3);
    send_word(CMD_MUL, $urandom);
    send_word(CMD_PUSH, 32'hffff_fff9);
    send_word(CMD_PUSH, 32'd2);
    send_word(CMD_DIV, $urandom);
    send_word(CMD_SUMALL, $urandom);
    send_word(CMD_PRODALL, $urandom);

    // deep stack under capacity 16, then capacity 3 lands below the count
    phase_caps = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd3, 5'd16, 5'd0, 5'd2, 5'd15};
    phase_caps[6] = CAP_W'($urandom_range(0, 31));
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_capacity(phase_caps[p]);
      steady = (p == 5);
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_word(pick_command(), pick_value());
    end
    drain();

    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
